/* sv/bfl_pkg.sv */
// Shared op codes, status codes and write-enable bundle for the buffer free list.
`default_nettype none

package bfl_pkg;

  // Fixed field widths of the command and result ports.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned SLOT_IN_W  = 4;
  localparam int unsigned BLOCK_IN_W = 16;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_LOOKUP   = 3'd3,
    OP_PEEK     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_LISTED   = 2'd1,
    ST_UNLISTED = 2'd2
  } status_e;

  // Write strobes into the link and tag store.
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic tag_we;
  } wr_en_t;

endpackage

`default_nettype wire

/* sv/bfl_store.sv */
// Link and tag memories with registered read and reset-value fix-up per entry.
`default_nettype none

module bfl_store #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned BLOCK_BITS = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  bfl_pkg::wr_en_t                          we_i,
  input  wire  [$clog2(NUM_SLOTS)-1:0]             next_wa_i,
  input  wire  [$clog2(NUM_SLOTS+1)-1:0]           next_wd_i,
  input  wire  [$clog2(NUM_SLOTS)-1:0]             prev_wa_i,
  input  wire  [$clog2(NUM_SLOTS+1)-1:0]           prev_wd_i,
  input  wire  [$clog2(NUM_SLOTS)-1:0]             tag_wa_i,
  input  wire  [BLOCK_BITS-1:0]                    tag_wd_i,
  input  wire  [$clog2(NUM_SLOTS)-1:0]             rd_addr_i,
  output logic [$clog2(NUM_SLOTS+1)-1:0]           rd_next_o,
  output logic [$clog2(NUM_SLOTS+1)-1:0]           rd_prev_o,
  output logic [BLOCK_BITS-1:0]                    rd_tag_o,
  output logic                                     rd_tag_valid_o
);

  import bfl_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned LINK_W = $clog2(NUM_SLOTS+1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

  logic [LINK_W-1:0]     next_mem [NUM_SLOTS];
  logic [LINK_W-1:0]     prev_mem [NUM_SLOTS];
  logic [BLOCK_BITS-1:0] tag_mem  [NUM_SLOTS];

  // An entry never written reads as its reset value.
  logic [NUM_SLOTS-1:0] nxt_wr_q, prv_wr_q, tag_vld_q;

  logic [SLOT_W-1:0]     rd_addr_q;
  logic                  nxt_ok_q, prv_ok_q, tag_ok_q;
  logic [LINK_W-1:0]     nxt_raw_q, prv_raw_q;
  logic [BLOCK_BITS-1:0] tag_raw_q;

  always_ff @(posedge clk_i) begin
    if (we_i.next_we) begin
      next_mem[next_wa_i] <= next_wd_i;
    end
    if (we_i.prev_we) begin
      prev_mem[prev_wa_i] <= prev_wd_i;
    end
    if (we_i.tag_we) begin
      tag_mem[tag_wa_i] <= tag_wd_i;
    end
    nxt_raw_q <= next_mem[rd_addr_i];
    prv_raw_q <= prev_mem[rd_addr_i];
    tag_raw_q <= tag_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_wr_q  <= '0;
      prv_wr_q  <= '0;
      tag_vld_q <= '0;
      rd_addr_q <= '0;
      nxt_ok_q  <= 1'b0;
      prv_ok_q  <= 1'b0;
      tag_ok_q  <= 1'b0;
    end else begin
      if (we_i.next_we) begin
        nxt_wr_q[next_wa_i] <= 1'b1;
      end
      if (we_i.prev_we) begin
        prv_wr_q[prev_wa_i] <= 1'b1;
      end
      if (we_i.tag_we) begin
        tag_vld_q[tag_wa_i] <= 1'b1;
      end
      rd_addr_q <= rd_addr_i;
      nxt_ok_q  <= nxt_wr_q[rd_addr_i];
      prv_ok_q  <= prv_wr_q[rd_addr_i];
      tag_ok_q  <= tag_vld_q[rd_addr_i];
    end
  end

  always_comb begin
    rd_next_o = nxt_ok_q ? nxt_raw_q : LINK_W'(rd_addr_q) + LINK_W'(1);
    if (prv_ok_q) begin
      rd_prev_o = prv_raw_q;
    end else if (rd_addr_q == '0) begin
      rd_prev_o = LINK_NONE;
    end else begin
      rd_prev_o = LINK_W'(rd_addr_q) - LINK_W'(1);
    end
    rd_tag_o       = tag_ok_q ? tag_raw_q : '0;
    rd_tag_valid_o = tag_ok_q;
  end

endmodule

`default_nettype wire

/* sv/buffer_free_list_manager_core.sv */
// Top level: doubly linked buffer free list with a sequenced link store and list walk.
// Sequence from the accepting edge to the done_o beat: peek, unknown op codes and rejected
// commands go through S_FIN to S_OUT; insert passes S_INS and S_INS2 first, remove S_RM1 and
// S_RM2, and lookup walks the list in S_LKW up to the hit, or to the list end on a miss.
// The walk reads one slot per cycle through the single read port of the link/tag store.
// busy drops the cycle after the done_o beat; a new command is accepted only in idle, no stalls.
// Reset (async, active low) lists every slot 0..NUM_SLOTS-1 in order, no tags valid.
`default_nettype none

module buffer_free_list_manager_core #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned BLOCK_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire  [bfl_pkg::OP_W-1:0]         op_i,
  input  wire  [bfl_pkg::SLOT_IN_W-1:0]    buffer_slot_i,
  input  wire  [bfl_pkg::BLOCK_IN_W-1:0]   block_number_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [bfl_pkg::SLOT_IN_W-1:0]    found_slot_o,
  output logic [bfl_pkg::BLOCK_IN_W-1:0]   head_block_o,
  output logic                             list_empty_o,
  output logic [bfl_pkg::STATUS_W-1:0]     status_o
);

  import bfl_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned LINK_W = $clog2(NUM_SLOTS+1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INS  = 8'b0000_0010,  // write the new slot's links and tag
    S_INS2 = 8'b0000_0100,  // hook the old head/tail onto the new slot
    S_RM1  = 8'b0000_1000,  // bridge neighbors around the removed slot
    S_RM2  = 8'b0001_0000,  // clear the removed slot's links
    S_LKW  = 8'b0010_0000,  // walk: compare one slot per cycle
    S_FIN  = 8'b0100_0000,  // read the head tag
    S_OUT  = 8'b1000_0000   // present the result beat
  } state_e;

  state_e state_q, state_d;

  logic [LINK_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [NUM_SLOTS-1:0]  on_list_q, on_list_d;
  op_e                   op_q, op_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [BLOCK_BITS-1:0] blk_q, blk_d;
  logic                  hit_q, hit_d;
  logic [SLOT_W-1:0]     found_q, found_d;
  status_e               status_q, status_d;
  logic [SLOT_W-1:0]     cur_q;

  // Store interface.
  wr_en_t                we;
  logic [SLOT_W-1:0]     next_wa, prev_wa, rd_addr;
  logic [LINK_W-1:0]     next_wd, prev_wd, rd_link;
  logic [LINK_W-1:0]     rd_next, rd_prev;
  logic [BLOCK_BITS-1:0] rd_tag;
  logic                  rd_tag_valid;

  // Command decode.
  op_e               op_in;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_listed;
  logic              accept;
  logic              tag_match;

  assign op_in       = op_e'(op_i);
  assign slot_ok     = 32'(buffer_slot_i) < NUM_SLOTS;
  assign slot_idx    = SLOT_W'(buffer_slot_i);
  assign slot_listed = slot_ok && on_list_q[slot_idx];
  assign accept      = start && (state_q == S_IDLE);

  // The compare unit: one tag per cycle during the walk.
  assign tag_match   = rd_tag_valid && (rd_tag == blk_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    on_list_d = on_list_q;
    op_d      = op_q;
    slot_d    = slot_q;
    blk_d     = blk_q;
    hit_d     = hit_q;
    found_d   = found_q;
    status_d  = status_q;
    we        = '0;
    next_wa   = slot_q;
    next_wd   = LINK_NONE;
    prev_wa   = slot_q;
    prev_wd   = LINK_NONE;
    rd_link   = head_q;

    unique case (state_q)
      S_IDLE: begin
        // Aim the read port at the slot to remove, or at the head for a walk.
        rd_link = (op_in == OP_LOOKUP) ? head_q : LINK_W'(slot_idx);
        if (accept) begin
          op_d     = op_in;
          slot_d   = slot_idx;
          blk_d    = BLOCK_BITS'(block_number_i);
          hit_d    = 1'b0;
          found_d  = '0;
          status_d = ST_OK;
          state_d  = S_FIN;
          unique case (op_in)
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (!slot_ok) begin
                status_d = ST_UNLISTED;
              end else if (slot_listed) begin
                status_d = ST_LISTED;
              end else begin
                on_list_d[slot_idx] = 1'b1;
                state_d             = S_INS;
              end
            end
            OP_REMOVE: begin
              if (!slot_listed) begin
                status_d = ST_UNLISTED;
              end else begin
                on_list_d[slot_idx] = 1'b0;
                state_d             = S_RM1;
              end
            end
            OP_LOOKUP: begin
              if (head_q != LINK_NONE) begin
                state_d = S_LKW;
              end
            end
            OP_PEEK: begin
              if (head_q != LINK_NONE) begin
                found_d = SLOT_W'(head_q);
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_INS: begin
        we.next_we = 1'b1;
        we.prev_we = 1'b1;
        we.tag_we  = 1'b1;
        if (op_q == OP_INS_HEAD) begin
          next_wd = head_q;
        end else begin
          prev_wd = tail_q;
        end
        state_d = S_INS2;
      end
      S_INS2: begin
        if (op_q == OP_INS_HEAD) begin
          if (head_q != LINK_NONE) begin
            we.prev_we = 1'b1;
            prev_wa    = SLOT_W'(head_q);
            prev_wd    = LINK_W'(slot_q);
          end else begin
            tail_d = LINK_W'(slot_q);
          end
          head_d = LINK_W'(slot_q);
        end else begin
          if (tail_q != LINK_NONE) begin
            we.next_we = 1'b1;
            next_wa    = SLOT_W'(tail_q);
            next_wd    = LINK_W'(slot_q);
          end else begin
            head_d = LINK_W'(slot_q);
          end
          tail_d = LINK_W'(slot_q);
        end
        state_d = S_FIN;
      end
      S_RM1: begin
        // Neighbors of the removed slot are on the read port now.
        if (rd_prev != LINK_NONE) begin
          we.next_we = 1'b1;
          next_wa    = SLOT_W'(rd_prev);
          next_wd    = rd_next;
        end else begin
          head_d = rd_next;
        end
        if (rd_next != LINK_NONE) begin
          we.prev_we = 1'b1;
          prev_wa    = SLOT_W'(rd_next);
          prev_wd    = rd_prev;
        end else begin
          tail_d = rd_prev;
        end
        state_d = S_RM2;
      end
      S_RM2: begin
        we.next_we = 1'b1;
        we.prev_we = 1'b1;
        state_d    = S_FIN;
      end
      S_LKW: begin
        // Compare the slot just read; on a miss, advance to its successor.
        rd_link = rd_next;
        if (tag_match) begin
          hit_d   = 1'b1;
          found_d = cur_q;
          state_d = S_FIN;
        end else if (rd_next == LINK_NONE) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        rd_link = head_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Never drive an out-of-range address; a "none" link reads slot 0 and is ignored.
  assign rd_addr = (rd_link == LINK_NONE) ? '0 : SLOT_W'(rd_link);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= LINK_W'(NUM_SLOTS - 1);
      on_list_q <= '1;
      op_q      <= OP_PEEK;
      hit_q     <= 1'b0;
      found_q   <= '0;
      status_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      on_list_q <= on_list_d;
      op_q      <= op_d;
      hit_q     <= hit_d;
      found_q   <= found_d;
      status_q  <= status_d;
    end
  end

  // Command payload and walk position; no reset needed.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    blk_q  <= blk_d;
    cur_q  <= rd_addr;
  end

  bfl_store #(
    .NUM_SLOTS  (NUM_SLOTS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .we_i           (we),
    .next_wa_i      (next_wa),
    .next_wd_i      (next_wd),
    .prev_wa_i      (prev_wa),
    .prev_wd_i      (prev_wd),
    .tag_wa_i       (slot_q),
    .tag_wd_i       (blk_q),
    .rd_addr_i      (rd_addr),
    .rd_next_o      (rd_next),
    .rd_prev_o      (rd_prev),
    .rd_tag_o       (rd_tag),
    .rd_tag_valid_o (rd_tag_valid)
  );

  // Result beat: head tag was read in the previous cycle at the current head.
  assign busy         = (state_q != S_IDLE);
  assign done_o       = (state_q == S_OUT);
  assign hit_o        = hit_q;
  assign found_slot_o = SLOT_IN_W'(found_q);
  assign list_empty_o = (head_q == LINK_NONE);
  assign head_block_o = (head_q == LINK_NONE) ? '0 : BLOCK_IN_W'(rd_tag);
  assign status_o     = status_q;

  // Head and tail are either both "none" or both valid.
  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == LINK_NONE) == (tail_q == LINK_NONE))
    else $error("head and tail pointers disagree on list emptiness");

  // Between commands, an empty list has no listed slots, and a non-empty one has some.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == LINK_NONE) == ($countones(on_list_q) == 0)))
    else $error("listed-slot flags disagree with head pointer");

  // The result strobe lasts one cycle and is followed by idle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result beat longer than one cycle");

  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not start the sequencer");

  // A hit is reported only with ok status.
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (status_o == ST_OK))
    else $error("lookup hit reported with error status");

endmodule

`default_nettype wire
